// File: sv/i2cs_pkg.sv
package i2cs_pkg;

  localparam int FRAME_SLOTS = 64;
  localparam int FRAME_BYTES = 32;
  localparam int BITS_PER_BYTE = 8;

  localparam int SLOT_W = $clog2(FRAME_SLOTS);
  localparam int BYTE_IDX_W = $clog2(FRAME_BYTES);
  localparam int BYTE_CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int BIT_CNT_W = $clog2(BITS_PER_BYTE + 1);

  localparam logic [1:0] FUNC_SDA_EDGE = 2'd0;
  localparam logic [1:0] FUNC_SCL_RISE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH    = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic       scl_level;
    logic       sda_level;
  } evt_t;

  typedef struct packed {
    logic [5:0] slot_number;
    logic [4:0] byte_position;
    logic [7:0] data_byte;
    logic       acked;
    logic       truncated;
    logic       last_byte;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_STOP,
    PEND_START
  } pend_t;

  typedef struct packed {
    logic scl_bit;
    logic sda;
    logic clr_busy;
    logic open_start;
    logic mark_emitted;
    logic emit_start;
    logic rd;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic can_finish;
    logic out_en;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// File: sv/i2cs_dp.sv
module i2cs_dp import i2cs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic       cfg_valid,
  input  logic       cfg_data,
  output logic       res_valid,
  input  logic       res_stall,
  output res_t       res
);

  logic                  output_enable;
  logic                  bus_busy;
  logic                  awaiting_first_start;
  logic [SLOT_W-1:0]     current_slot;
  logic [BIT_CNT_W-1:0]  bit_count;
  logic [BYTE_CNT_W-1:0] byte_count;
  logic                  frame_emitted;
  logic                  overflowed;
  logic [7:0]            cur_byte;
  logic [BYTE_IDX_W-1:0] rd_idx;
  logic [8:0]            rd_data;
  logic [8:0]            mem [FRAME_BYTES];
  logic                  room;

  assign room = byte_count < BYTE_CNT_W'(FRAME_BYTES);

  assign sts.busy       = bus_busy;
  assign sts.can_finish = !frame_emitted && (byte_count != '0);
  assign sts.out_en     = output_enable;
  assign sts.last       = (BYTE_CNT_W'(rd_idx) + BYTE_CNT_W'(1)) == byte_count;
  assign sts.out_free   = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (cmd.scl_bit && bus_busy && room) begin
      if (bit_count == BIT_CNT_W'(BITS_PER_BYTE)) begin
        mem[byte_count[BYTE_IDX_W-1:0]] <= {~cmd.sda, cur_byte};
      end
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scl_bit && bit_count != BIT_CNT_W'(BITS_PER_BYTE)) begin
      cur_byte <= {cur_byte[6:0], cmd.sda};
    end
    if (cmd.emit_start) begin
      rd_idx <= '0;
    end else if (cmd.load) begin
      rd_idx <= rd_idx + BYTE_IDX_W'(1);
    end
    if (cmd.load) begin
      res.slot_number   <= 6'(current_slot);
      res.byte_position <= 5'(rd_idx);
      res.data_byte     <= rd_data[7:0];
      res.acked         <= rd_data[8];
      res.truncated     <= overflowed;
      res.last_byte     <= sts.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enable        <= 1'b0;
      bus_busy             <= 1'b0;
      awaiting_first_start <= 1'b1;
      current_slot         <= '0;
      bit_count            <= '0;
      byte_count           <= '0;
      frame_emitted        <= 1'b0;
      overflowed           <= 1'b0;
      res_valid            <= 1'b0;
    end else begin
      if (cfg_valid) begin
        output_enable <= cfg_data;
      end
      if (cmd.load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cmd.scl_bit) begin
        if (bit_count != BIT_CNT_W'(BITS_PER_BYTE)) begin
          bit_count <= bit_count + BIT_CNT_W'(1);
        end else begin
          bit_count <= '0;
          if (room) begin
            byte_count <= byte_count + BYTE_CNT_W'(1);
          end else begin
            overflowed <= 1'b1;
          end
        end
      end
      if (cmd.mark_emitted) begin
        frame_emitted <= 1'b1;
      end
      if (cmd.clr_busy) begin
        bus_busy <= 1'b0;
      end
      if (cmd.open_start) begin
        bus_busy      <= 1'b1;
        bit_count     <= '0;
        byte_count    <= '0;
        frame_emitted <= 1'b0;
        overflowed    <= 1'b0;
        if (awaiting_first_start) begin
          awaiting_first_start <= 1'b0;
        end else if (current_slot == SLOT_W'(FRAME_SLOTS - 1)) begin
          current_slot <= '0;
        end else begin
          current_slot <= current_slot + SLOT_W'(1);
        end
      end
    end
  end

endmodule

// File: sv/i2cs_ctrl.sv
module i2cs_ctrl import i2cs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   evt_valid,
  input  evt_t   evt,
  output logic   evt_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;
  pend_t  pend, pend_next;
  pend_t  act;
  logic   fin;

  assign evt_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= PEND_NONE;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    cmd.sda    = evt.sda_level;
    act        = PEND_NONE;
    fin        = 1'b0;
    case (state)
      ST_IDLE: begin
        case (evt.func)
          FUNC_SDA_EDGE: begin
            if (evt.scl_level) begin
              if (sts.busy && evt.sda_level) begin
                fin = 1'b1;
                act = PEND_STOP;
              end else if (!sts.busy && !evt.sda_level) begin
                fin = 1'b1;
                act = PEND_START;
              end
            end
          end
          FUNC_SCL_RISE: cmd.scl_bit = evt_valid && sts.busy;
          FUNC_FLUSH:    fin = 1'b1;
          default: ;
        endcase
        if (evt_valid) begin
          cmd.mark_emitted = fin && sts.can_finish;
          if (fin && sts.can_finish && sts.out_en) begin
            cmd.emit_start = 1'b1;
            pend_next      = act;
            state_next     = ST_READ;
          end else begin
            cmd.clr_busy   = (act == PEND_STOP);
            cmd.open_start = (act == PEND_START);
          end
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.last) begin
            cmd.clr_busy   = (pend == PEND_STOP);
            cmd.open_start = (pend == PEND_START);
            pend_next      = PEND_NONE;
            state_next     = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: sv/i2c_bus_sniffer_core.sv
// Passive I2C bus monitor fed with sampled bus events.
// Event channel (evt_valid / evt_stall / evt): one transaction per SDA edge,
// SCL rising edge or flush request, with the SCL and SDA levels at the event.
// Result channel (res_valid / res_stall / res): one transaction per captured
// byte of a finished frame, in byte order, when output is enabled.
// Config channel (cfg_valid / cfg_ready / cfg_data): output enable bit,
// always ready; write it only while no event is in progress.
// Flow: an event that finishes no frame is accepted without stalling, and the
// next event is taken in the following cycle. An event that emits a frame
// holds evt_stall high while its bytes are sent: each byte is first read from
// the frame buffer and then loaded into the output register. While res_stall
// holds a result, the next byte waits after its buffer read and evt_stall
// stays high; once the last byte is loaded, events are taken again even if
// that result is still stalled. Stop and start bookkeeping is applied in
// the same cycle as the last byte of the frame is loaded.
// Reset (rst, synchronous): bus free, slot 0 pending for the first start,
// frame empty, output disabled, no result pending. The frame buffer is not
// cleared; only bytes already captured are ever read.
module i2c_bus_sniffer_core import i2cs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic evt_valid,
  output logic evt_stall,
  input  evt_t evt,
  output logic res_valid,
  input  logic res_stall,
  output res_t res,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  i2cs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt       (evt),
    .evt_stall (evt_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  i2cs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  a_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(evt_stall))
    else $error("result loaded while events were accepted");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) && res.last_byte |-> !evt_stall)
    else $error("event channel still stalled after last byte");

  a_trunc_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.truncated && res.last_byte |->
      res.byte_position == 5'(FRAME_BYTES - 1))
    else $error("truncated frame does not end at buffer limit");

endmodule

// File: tb/i2c_bus_sniffer_core_test.sv
`timescale 1ns / 1ps

module i2c_bus_sniffer_core_test;
  import i2cs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 12;

  logic clk;
  logic rst = 1'b1;
  logic evt_valid = 1'b0;
  logic evt_stall;
  evt_t evt = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  i2c_bus_sniffer_core i_dut (
    .clk(clk),
    .rst(rst),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt(evt),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  evt_t bus_events[$];
  res_t expected_bytes[$];
  bit   enable_writes[$];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   events_queued = 0;
  int   errors = 0;
  int   cycles = 0;

  // shadow of the monitor state
  bit         emit_en = 1'b0;
  bit         bus_busy = 1'b0;
  bit         first_start_pending = 1'b1;
  logic [5:0] cur_slot = '0;
  logic [7:0] frame_data[FRAME_BYTES];
  bit         frame_acks[FRAME_BYTES];
  int         bit_cnt = 0;
  int         byte_cnt = 0;
  bit         frame_done = 1'b0;
  bit         frame_overflow = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  task clear_frame();
    for (int k = 0; k < FRAME_BYTES; k++) begin
      frame_data[k] = '0;
      frame_acks[k] = 1'b0;
    end
    bit_cnt = 0;
    byte_cnt = 0;
    frame_done = 1'b0;
    frame_overflow = 1'b0;
  endtask

  task finalize_frame();
    res_t r;
    if (frame_done || byte_cnt == 0) return;
    frame_done = 1'b1;
    if (!emit_en) return;
    for (int k = 0; k < byte_cnt; k++) begin
      r.slot_number = cur_slot;
      r.byte_position = 5'(k);
      r.data_byte = frame_data[k];
      r.acked = frame_acks[k];
      r.truncated = frame_overflow;
      r.last_byte = (k + 1 == byte_cnt);
      expected_bytes.push_back(r);
    end
  endtask

  task apply_bus_event(input evt_t e);
    case (e.func)
      FUNC_SDA_EDGE: begin
        if (e.scl_level) begin
          if (bus_busy) begin
            if (e.sda_level) begin
              finalize_frame();
              bus_busy = 1'b0;
            end
          end else if (!e.sda_level) begin
            finalize_frame();
            bus_busy = 1'b1;
            if (first_start_pending) first_start_pending = 1'b0;
            else if (cur_slot == FRAME_SLOTS - 1) cur_slot = '0;
            else cur_slot = cur_slot + 6'd1;
            clear_frame();
          end
        end
      end
      FUNC_SCL_RISE: begin
        if (bus_busy) begin
          if (bit_cnt < BITS_PER_BYTE) begin
            if (byte_cnt < FRAME_BYTES)
              frame_data[byte_cnt] = {frame_data[byte_cnt][6:0], e.sda_level};
            bit_cnt++;
          end else begin
            if (byte_cnt < FRAME_BYTES) begin
              frame_acks[byte_cnt] = !e.sda_level;
              byte_cnt++;
            end else begin
              frame_overflow = 1'b1;
            end
            bit_cnt = 0;
          end
        end
      end
      FUNC_FLUSH: finalize_frame();
      default: ;
    endcase
  endtask

  task check_result(input res_t got);
    res_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected result %p", got));
      return;
    end
    want = expected_bytes.pop_front();
    if (got.slot_number !== want.slot_number)
      report_mismatch($sformatf("slot_number %0d, want %0d", got.slot_number,
                                want.slot_number));
    if (got.byte_position !== want.byte_position)
      report_mismatch($sformatf("byte_position %0d, want %0d", got.byte_position,
                                want.byte_position));
    if (got.data_byte !== want.data_byte)
      report_mismatch($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
    if (got.acked !== want.acked)
      report_mismatch($sformatf("acked %b, want %b", got.acked, want.acked));
    if (got.truncated !== want.truncated)
      report_mismatch($sformatf("truncated %b, want %b", got.truncated, want.truncated));
    if (got.last_byte !== want.last_byte)
      report_mismatch($sformatf("last_byte %b, want %b", got.last_byte, want.last_byte));
  endtask

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (!evt_valid || !evt_stall) begin
      if (bus_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        evt <= bus_events.pop_front();
        evt_valid <= 1'b1;
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid && enable_writes.size() != 0) begin
      cfg_data <= enable_writes.pop_front();
      cfg_valid <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) emit_en = cfg_data;
      if (res_valid && !res_stall) check_result(res);
      if (evt_valid && !evt_stall) apply_bus_event(evt);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("i2c_bus_sniffer_core verification failed");
      $finish;
    end
  end

  task push_evt(input logic [1:0] f, input bit scl, input bit sda);
    evt_t e;
    e.func = f;
    e.scl_level = scl;
    e.sda_level = sda;
    bus_events.push_back(e);
    events_queued++;
  endtask

  task push_byte(input logic [7:0] b, input bit ack);
    for (int i = 7; i >= 0; i--) push_evt(FUNC_SCL_RISE, 1'($urandom_range(1)), b[i]);
    push_evt(FUNC_SCL_RISE, 1'($urandom_range(1)), !ack);
  endtask

  task push_start_stop(input bit stop_cond);
    push_evt(FUNC_SDA_EDGE, 1'b1, stop_cond);
  endtask

  task wait_idle();
    do @(negedge clk);
    while (bus_events.size() != 0 || evt_valid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_enable(input bit v);
    enable_writes.push_back(v);
    do @(negedge clk);
    while (enable_writes.size() != 0 || cfg_valid);
  endtask

  task gen_transfer(input int forced_bytes);
    int nbytes;
    int pick;
    if (forced_bytes < 0 && $urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4))
        push_evt(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      return;
    end
    push_start_stop(1'b0);
    if (forced_bytes >= 0) begin
      nbytes = forced_bytes;
    end else begin
      pick = $urandom_range(99);
      nbytes = pick < 35 ? 0 : pick < 75 ? $urandom_range(1, 2) : $urandom_range(3, 6);
    end
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(9) == 0) push_evt(FUNC_SDA_EDGE, 1'b0, 1'($urandom_range(1)));
      if ($urandom_range(24) == 0) push_start_stop(1'b0);
      push_byte(8'($urandom), 1'($urandom_range(1)));
    end
    pick = $urandom_range(99);
    if (pick < 55) begin
      push_start_stop(1'b1);
    end else if (pick < 70) begin
      push_evt(FUNC_FLUSH, 1'($urandom_range(1)), 1'($urandom_range(1)));
      push_start_stop(1'b1);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 8))
        push_evt(FUNC_SCL_RISE, 1'($urandom_range(1)), 1'($urandom_range(1)));
      push_start_stop(1'b1);
    end else if (pick < 95) begin
      push_evt(FUNC_FLUSH, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task run_random(input int count);
    int stop_at;
    stop_at = events_queued + count;
    while (events_queued < stop_at) gen_transfer(-1);
  endtask

  initial begin
    clear_frame();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_enable(1'b1);

    push_evt(FUNC_SCL_RISE, 1'b1, 1'b1);
    push_evt(FUNC_SDA_EDGE, 1'b1, 1'b1);
    push_evt(FUNC_SDA_EDGE, 1'b0, 1'b0);
    push_evt(FUNC_UNUSED, 1'b1, 1'b0);
    push_evt(FUNC_FLUSH, 1'b0, 1'b0);
    push_start_stop(1'b0);
    push_byte(8'hFF, 1'b1);
    push_evt(FUNC_SDA_EDGE, 1'b0, 1'b1);
    push_start_stop(1'b0);
    push_byte(8'h00, 1'b0);
    repeat (3) push_evt(FUNC_SCL_RISE, 1'b0, 1'b1);
    push_evt(FUNC_FLUSH, 1'b1, 1'b1);
    push_start_stop(1'b1);
    wait_idle();

    send_idle_pct = 30;
    recv_idle_pct = 77;
    run_random(30);
    gen_transfer(FRAME_BYTES + 1);
    wait_idle();

    write_enable(1'b0);
    send_idle_pct = 77;
    recv_idle_pct = 30;
    run_random(30);
    wait_idle();
    write_enable(1'b1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_start_stop(1'b1);
    repeat (FRAME_SLOTS - int'(cur_slot)) begin
      push_start_stop(1'b0);
      push_start_stop(1'b1);
    end
    run_random(20);
    push_start_stop(1'b1);
    wait_idle();

    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_bytes.size()));
    if (errors == 0) begin
      $display("i2c_bus_sniffer_core verification clean");
    end else begin
      $display("i2c_bus_sniffer_core verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/i2cs_pkg.sv
sv/i2cs_dp.sv
sv/i2cs_ctrl.sv
sv/i2c_bus_sniffer_core.sv
tb/i2c_bus_sniffer_core_test.sv
